FILE: src/lkd_pkg.sv
package lkd_pkg;

    // Command codes carried in the input tuser field
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_SEND  = 2'd1,
        CMD_FIXED = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND   = 2'd1;

    localparam logic [7:0] READ_COMMAND_RST = 8'h42;
    localparam logic [7:0] TURNAROUND_RST   = 8'd1;

    // Key bytes read per key scan (1 to 4)
    localparam int unsigned KEY_BYTES = 4;
    localparam logic [5:0]  READ_BITS = 6'(KEY_BYTES * 8);
    localparam logic [4:0]  BITS_BYTE = 5'd8;
    localparam logic [4:0]  BITS_PAIR = 5'd16;

    // Field widths of the streams
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 2;
    localparam int unsigned OUT_DATA_W = 40;

    // Pin levels and status for one tick
    typedef struct packed {
        logic        stb;
        logic        clk;
        logic        dio_out;
        logic        dio_drive;
        logic        busy;
        logic        keys_valid;
        logic [31:0] key_data;
    } t_result;

endpackage

FILE: src/lkd_seq.sv
module lkd_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  lkd_pkg::t_cmd    i_cmd,
    input  logic [7:0]       i_address,
    input  logic [7:0]       i_data_byte,
    input  logic             i_dio_in,
    input  logic [7:0]       i_read_command,
    input  logic [7:0]       i_turnaround,
    output lkd_pkg::t_result o_result
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_SEND  = 3'd2,
        PH_TURN  = 3'd3,
        PH_READ  = 3'd4,
        PH_STOP  = 3'd5
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [4:0]  r_bit_count, n_bit_count;
    logic [15:0] r_out_shift, n_out_shift;
    logic [4:0]  r_bits,      n_bits;
    logic        r_low_half,  n_low_half;
    logic [7:0]  r_wait,      n_wait;
    logic [31:0] r_key_shift, n_key_shift;
    logic        r_is_read,   n_is_read;

    logic [5:0]  w_bc_inc;
    logic [7:0]  w_wait_dec;

    assign w_bc_inc   = {1'b0, r_bit_count} + 6'd1;
    assign w_wait_dec = r_wait - 8'd1;

    // Next state and pin levels for the current tick
    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_out_shift = r_out_shift;
        n_bits      = r_bits;
        n_low_half  = r_low_half;
        n_wait      = r_wait;
        n_key_shift = r_key_shift;
        n_is_read   = r_is_read;

        o_result            = '0;
        o_result.stb        = 1'b1;
        o_result.clk        = 1'b1;
        o_result.dio_out    = 1'b1;
        o_result.dio_drive  = 1'b1;
        o_result.busy       = 1'b1;

        unique case (r_phase)
            PH_IDLE: begin
                o_result.busy = 1'b0;
                if (i_cmd != lkd_pkg::CMD_NONE) begin
                    o_result.busy = 1'b1;
                    o_result.stb  = 1'b0;
                    n_bit_count   = '0;
                    n_low_half    = 1'b0;
                    n_is_read     = 1'b0;
                    n_phase       = PH_SEND;
                    unique case (i_cmd)
                        lkd_pkg::CMD_SEND: begin
                            n_out_shift = {8'd0, i_data_byte};
                            n_bits      = lkd_pkg::BITS_BYTE;
                        end
                        lkd_pkg::CMD_FIXED: begin
                            n_out_shift = {i_data_byte, i_address};
                            n_bits      = lkd_pkg::BITS_PAIR;
                        end
                        lkd_pkg::CMD_READ: begin
                            n_out_shift = {8'd0, i_read_command};
                            n_bits      = lkd_pkg::BITS_BYTE;
                            n_is_read   = 1'b1;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_SEND: begin
                o_result.stb     = 1'b0;
                o_result.dio_out = r_out_shift[0];
                if (!r_low_half) begin
                    o_result.clk = 1'b0;
                    n_low_half   = 1'b1;
                end else begin
                    n_low_half  = 1'b0;
                    n_out_shift = {1'b0, r_out_shift[15:1]};
                    if (w_bc_inc >= {1'b0, r_bits}) begin
                        n_bit_count = '0;
                        if (r_is_read) begin
                            n_key_shift = '0;
                            if (i_turnaround == 8'd0) begin
                                n_phase = PH_READ;
                            end else begin
                                n_wait  = i_turnaround;
                                n_phase = PH_TURN;
                            end
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end else begin
                        n_bit_count = w_bc_inc[4:0];
                    end
                end
            end
            PH_TURN: begin
                o_result.stb       = 1'b0;
                o_result.dio_drive = 1'b0;
                n_wait             = w_wait_dec;
                if (w_wait_dec == 8'd0) begin
                    n_phase     = PH_READ;
                    n_bit_count = '0;
                    n_low_half  = 1'b0;
                end
            end
            PH_READ: begin
                o_result.stb       = 1'b0;
                o_result.dio_drive = 1'b0;
                if (!r_low_half) begin
                    o_result.clk = 1'b0;
                    n_low_half   = 1'b1;
                end else begin
                    n_low_half = 1'b0;
                    n_key_shift[r_bit_count] = r_key_shift[r_bit_count] | i_dio_in;
                    if (w_bc_inc >= lkd_pkg::READ_BITS) begin
                        n_bit_count = '0;
                        n_phase     = PH_STOP;
                    end else begin
                        n_bit_count = w_bc_inc[4:0];
                    end
                end
            end
            PH_STOP: begin
                if (r_is_read) begin
                    o_result.keys_valid = 1'b1;
                    o_result.key_data   = r_key_shift;
                end
                n_is_read = 1'b0;
                n_phase   = PH_IDLE;
            end
            default: begin
                o_result.busy = 1'b0;
                n_phase       = PH_IDLE;
            end
        endcase
    end

    // Sequencer state, advanced once per tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_out_shift <= '0;
            r_bits      <= '0;
            r_low_half  <= 1'b0;
            r_wait      <= '0;
            r_key_shift <= '0;
            r_is_read   <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_out_shift <= n_out_shift;
            r_bits      <= n_bits;
            r_low_half  <= n_low_half;
            r_wait      <= n_wait;
            r_key_shift <= n_key_shift;
            r_is_read   <= n_is_read;
        end
    end

    // Stop tick always returns to idle
    a_stop_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_STOP |=> r_phase == PH_IDLE)
        else $error("stop tick did not return to idle");

    // Turnaround and read only happen inside a key scan
    a_read_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TURN || r_phase == PH_READ) |-> r_is_read)
        else $error("read phase without key scan");

    // Turnaround counter never sits at zero
    a_wait_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TURN |-> r_wait != 8'd0)
        else $error("turnaround entered with zero count");

    // No command keeps the sequencer idle
    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_IDLE && i_cmd == lkd_pkg::CMD_NONE
        |=> r_phase == PH_IDLE)
        else $error("left idle without a command");

endmodule

FILE: src/led_key_driver_serial_master.sv
// Pin sequencer for a three-wire strobe/clock/data LED and key driver. Every
// input word is one pin tick and produces exactly one output word holding the
// strobe, clock and data pin levels for that tick plus busy and key status.
// One word is accepted per clock cycle: an input register feeds the tick
// logic and a result register holds the pin word, so throughput is one word
// per cycle, limited only by output backpressure.
// Commands (send byte, fixed write, read keys) are taken only while idle.
// Bits go LSB first, one clock-low and one clock-high tick per bit; read data
// is sampled on the clock-high tick. key_data is nonzero only on the stop
// tick of a key read, where keys_valid is set.
module led_key_driver_serial_master (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // address[7:0], data_byte[15:8], dio_in[16], zero [23:17]
    input  logic [lkd_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // command[1:0]
    input  logic [lkd_pkg::IN_USER_W-1:0]        i_s_axis_tuser,
    // Output stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // stb[0], clk_res[1], dio_out[2], dio_drive[3], busy_res[4],
    // keys_valid[5], key_data[37:6], zero [39:38]
    output logic [lkd_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lkd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);

    logic             r_in_valid;
    lkd_pkg::t_cmd    r_cmd;
    logic [7:0]       r_address;
    logic [7:0]       r_data_byte;
    logic             r_dio_in;
    logic             r_out_valid;
    lkd_pkg::t_result r_result;
    logic [7:0]       r_read_command;
    logic [7:0]       r_turnaround;

    logic             w_adv;
    logic             w_step;
    lkd_pkg::t_result w_result;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_step          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_command <= lkd_pkg::READ_COMMAND_RST;
            r_turnaround   <= lkd_pkg::TURNAROUND_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lkd_pkg::CFG_READ_COMMAND) begin
                r_read_command <= i_cfg_data;
            end else if (i_cfg_index == lkd_pkg::CFG_TURNAROUND) begin
                r_turnaround <= i_cfg_data;
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_cmd       <= lkd_pkg::t_cmd'(i_s_axis_tuser);
            r_address   <= i_s_axis_tdata[7:0];
            r_data_byte <= i_s_axis_tdata[15:8];
            r_dio_in    <= i_s_axis_tdata[16];
        end
    end

    lkd_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_cmd          (r_cmd),
        .i_address      (r_address),
        .i_data_byte    (r_data_byte),
        .i_dio_in       (r_dio_in),
        .i_read_command (r_read_command),
        .i_turnaround   (r_turnaround),
        .o_result       (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_m_axis_tdata = {2'b00, r_result.key_data, r_result.keys_valid,
                             r_result.busy, r_result.dio_drive, r_result.dio_out,
                             r_result.clk, r_result.stb};

endmodule
